// File: design/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Types, constants and the CRC-8 byte update shared by the frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned MaxDataBytes = 28;
  localparam int unsigned MinLength    = 3;
  localparam int unsigned MaxLength    = 31;
  localparam int unsigned PayloadBytes = 4;

  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcInit = 8'h00;
  localparam logic [7:0] CrcHiOk = 8'h00;

  localparam logic [1:0] CfgHeader  = 2'd0;
  localparam logic [1:0] CfgMaxCmd  = 2'd1;
  localparam logic [1:0] CfgFanCmd  = 2'd2;
  localparam logic [1:0] CfgLedsCmd = 2'd3;

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhLength = 3'd1,
    PhCmd    = 3'd2,
    PhData   = 3'd3,
    PhCrcLo  = 3'd4,
    PhCrcHi  = 3'd5
  } phase_e;

  typedef logic [PayloadBytes-1:0][7:0] payload_t;

  typedef struct packed {
    logic       done;
    logic [7:0] cmd;
    payload_t   pay;
  } result_t;

  // MSB first, no reflection, no final xor
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// File: design/crc8_checked_frame_parser.sv
// ----------------------------------------------------------------------------
// crc8_checked_frame_parser
// Length-prefixed frame parser with running CRC-8 check and payload capture.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while the skid is empty; each yields a
// registered result word: frame-done flag on tlast, held command and 4-byte
// payload in tdata. CRC update and parse step are combinational; a two-entry
// output stage (register plus skid) takes one more byte while the sink stalls,
// so the rate is one word per clock while the sink is ready. Frame: header,
// length (3..31), command (<= max_command), data, CRC low, CRC high (must be
// zero). The user must write config registers only while idle; not enforced.
module crc8_checked_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] command_code, [15:8] payload_zero,
                                        // [23:16] payload_one, [31:24] payload_two,
                                        // [39:32] payload_three
  output logic        m_axis_tlast_o    // frame_done
);
  import cfp_pkg::*;

  logic [7:0] header_q, max_cmd_q, fan_cmd_q, leds_cmd_q;

  phase_e     phase_q, phase_d;
  logic [4:0] cnt_q, cnt_d;
  logic [4:0] pos_q, pos_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] cmd_q, cmd_d;
  payload_t   pay_q, pay_d;
  payload_t   fdb_q, fdb_cur;

  result_t    res;
  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;

  logic       acc, pop;
  logic [7:0] b;
  logic       len_ok, cmd_ok, last_data;
  logic [8:0] len_minus;

  assign b   = s_axis_tdata_i;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign pop = out_valid_q && m_axis_tready_i;

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_q.done;
  assign m_axis_tdata_o  = {out_q.pay, out_q.cmd};

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= 8'd170;
      max_cmd_q  <= 8'd6;
      fan_cmd_q  <= 8'd4;
      leds_cmd_q <= 8'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeader:  header_q   <= cfg_data_i;
        CfgMaxCmd:  max_cmd_q  <= cfg_data_i;
        CfgFanCmd:  fan_cmd_q  <= cfg_data_i;
        CfgLedsCmd: leds_cmd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign len_minus = {1'b0, b} - 9'(MinLength);
  assign len_ok    = (b >= 8'(MinLength)) && (b <= 8'(MaxLength))
                     && (len_minus <= 9'(MaxDataBytes));
  assign cmd_ok    = (b <= max_cmd_q);
  assign last_data = ((pos_q + 5'd1) >= cnt_q);

  // next phase
  always_comb begin
    phase_d = PhHeader;
    case (phase_q)
      PhHeader: phase_d = (b == header_q) ? PhLength : PhHeader;
      PhLength: phase_d = len_ok ? PhCmd : PhHeader;
      PhCmd: begin
        if (!cmd_ok) begin
          phase_d = PhHeader;
        end else begin
          phase_d = (cnt_q == 5'd0) ? PhCrcLo : PhData;
        end
      end
      PhData:  phase_d = last_data ? PhCrcLo : PhData;
      PhCrcLo: phase_d = (b == crc_q) ? PhCrcHi : PhHeader;
      PhCrcHi: phase_d = PhHeader;
      default: phase_d = (b == header_q) ? PhLength : PhHeader;
    endcase
  end

  // current byte forwarded into the captured data bytes
  always_comb begin
    for (int i = 0; i < PayloadBytes; i++) begin
      fdb_cur[i] = (pos_q == 5'(i)) ? b : fdb_q[i];
    end
  end

  // datapath and result
  always_comb begin
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    crc_d    = crc_q;
    cmd_d    = cmd_q;
    pay_d    = pay_q;
    res.done = 1'b0;
    case (phase_q)
      PhLength: begin
        if (len_ok) begin
          cnt_d = len_minus[4:0];
          pos_d = 5'd0;
          crc_d = crc8_update(CrcInit, b);
        end
      end
      PhCmd: begin
        if (cmd_ok) begin
          cmd_d    = b;
          crc_d    = crc8_update(crc_q, b);
          pay_d[0] = 8'd0;
        end
      end
      PhData: begin
        crc_d = crc8_update(crc_q, b);
        pos_d = pos_q + 5'd1;
        if (last_data) begin
          if (cmd_q == fan_cmd_q) begin
            if (cnt_q >= 5'd1) begin
              pay_d[0] = fdb_cur[0];
            end
          end else if (cmd_q == leds_cmd_q) begin
            if (cnt_q >= 5'(PayloadBytes)) begin
              pay_d = fdb_cur;
            end
          end
        end
      end
      PhCrcHi: res.done = (b == CrcHiOk);
      default: ;
    endcase
    res.cmd = cmd_d;
    res.pay = pay_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      cnt_q   <= 5'd0;
      pos_q   <= 5'd0;
      crc_q   <= CrcInit;
      cmd_q   <= 8'd0;
      pay_q   <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      cmd_q   <= cmd_d;
      pay_q   <= pay_d;
    end
  end

  // captured data bytes, no reset
  always_ff @(posedge clk_i) begin
    if (acc && phase_q == PhData && pos_q[4:2] == 3'd0) begin
      fdb_q[pos_q[1:0]] <= b;
    end
  end

  // output register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= acc;
      end
    end else if (acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (acc) begin
      skid_q <= res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without output word");

  a_data_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (pos_q < cnt_q))
    else $error("data position past data count");

  a_done_only_crc_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.done) |-> (phase_q == PhCrcHi))
    else $error("frame done outside CRC high phase");

  a_cmd_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && phase_q == PhCmd && cmd_ok) |=> (cmd_q == $past(b) && pay_q[0] == 8'd0))
    else $error("accepted command not held");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of crc8_checked_frame_parser: frames built with a valid
// CRC-8, with broken length, command, CRC or truncation, and random noise are
// fed one byte per word. A software parser follows every accepted byte and
// queues the word the block must return; each returned word is compared
// field by field. Both sides stall at random, and configuration is changed
// between tests and within random traffic, each time after the output drains.
// ----------------------------------------------------------------------------
module tb;
  import cfp_pkg::*;

  localparam int unsigned ByteBudget    = 1050;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned DrainCycles   = 4;

  typedef enum int unsigned {
    FlawNone,
    FlawLength,
    FlawCommand,
    FlawCrcLo,
    FlawCrcHi,
    FlawCut
  } flaw_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_idx_i       = CfgHeader;
  logic [7:0]  cfg_data_i      = 8'h00;
  logic        s_axis_tvalid_i = 1'b0;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  crc8_checked_frame_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // parser copy: configuration
  logic [7:0] hdr_value = 8'hAA;
  logic [7:0] max_cmd   = 8'd6;
  logic [7:0] fan_cmd   = 8'd4;
  logic [7:0] leds_cmd  = 8'd5;

  // parser copy: state
  phase_e      model_phase = PhHeader;
  int unsigned data_cnt    = 0;
  int unsigned data_pos    = 0;
  logic [7:0]  frame_crc   = CrcInit;
  logic [7:0]  held_cmd    = 8'h00;
  payload_t    first_bytes = '0;
  payload_t    payload     = '0;

  result_t     words_due[$];
  result_t     due_word;
  int unsigned mismatches   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_stall     = 0;
  int unsigned hold_left    = 0;
  bit          hold_req     = 1'b0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = (r << 1) ^ (r[7] ? CrcPoly : 8'h00);
    return r;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r.done = 1'b0;
    case (model_phase)
      PhLength: begin
        if (b < MinLength || b > MaxLength) begin
          model_phase = PhHeader;
        end else begin
          data_cnt    = b - MinLength;
          data_pos    = 0;
          frame_crc   = crc8_next(CrcInit, b);
          model_phase = PhCmd;
        end
      end
      PhCmd: begin
        if (b > max_cmd) begin
          model_phase = PhHeader;
        end else begin
          held_cmd    = b;
          frame_crc   = crc8_next(frame_crc, b);
          payload[0]  = 8'h00;
          model_phase = (data_cnt == 0) ? PhCrcLo : PhData;
        end
      end
      PhData: begin
        if (data_pos < PayloadBytes) begin
          first_bytes[2'(data_pos)] = b;
        end
        frame_crc = crc8_next(frame_crc, b);
        data_pos++;
        if (data_pos >= data_cnt) begin
          if (held_cmd == fan_cmd) begin
            if (data_cnt >= 1) payload[0] = first_bytes[0];
          end else if (held_cmd == leds_cmd) begin
            if (data_cnt >= PayloadBytes) payload = first_bytes;
          end
          model_phase = PhCrcLo;
        end
      end
      PhCrcLo: begin
        model_phase = (b == frame_crc) ? PhCrcHi : PhHeader;
      end
      PhCrcHi: begin
        r.done      = (b == CrcHiOk);
        model_phase = PhHeader;
      end
      default: begin
        model_phase = (b == hdr_value) ? PhLength : PhHeader;
      end
    endcase
    r.cmd = held_cmd;
    r.pay = payload;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // input prediction, output compare, sink stall draw, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        words_due.push_back(parse_byte(s_axis_tdata_i));
        quiet_cycles = 0;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        quiet_cycles = 0;
        rx_stall = rx_calm ? 0 : $urandom_range(0, 9);
        if (words_due.size() == 0) begin
          $display("%0t unexpected word: expected none, got last=%0b data=%h",
                   $time, m_axis_tlast_o, m_axis_tdata_o);
          mismatches++;
        end else begin
          due_word = words_due.pop_front();
          check_field("frame_done", 8'(due_word.done), 8'(m_axis_tlast_o));
          check_field("command_code", due_word.cmd, m_axis_tdata_o[7:0]);
          for (int k = 0; k < PayloadBytes; k++) begin
            check_field($sformatf("payload[%0d]", k), due_word.pay[2'(k)],
                        m_axis_tdata_o[8*k+8 +: 8]);
          end
        end
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // sink side
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (rx_stall > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // leaves the write enable high; configure lowers it
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgHeader:  hdr_value = value;
      CfgMaxCmd:  max_cmd   = value;
      CfgFanCmd:  fan_cmd   = value;
      CfgLedsCmd: leds_cmd  = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [7:0] hdr, input logic [7:0] mx,
                           input logic [7:0] fan, input logic [7:0] leds);
    drain();
    write_reg(CfgHeader, hdr);
    write_reg(CfgMaxCmd, mx);
    write_reg(CfgFanCmd, fan);
    write_reg(CfgLedsCmd, leds);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int unsigned n_data,
                            input flaw_e flaw);
    logic [7:0]  len;
    logic [7:0]  acc;
    logic [7:0]  b;
    int unsigned stop;
    len = 8'(n_data + MinLength);
    send_byte(hdr_value);
    if (flaw == FlawLength) begin
      send_byte(8'($urandom_range(0, 1) ? $urandom_range(0, MinLength - 1)
                                        : $urandom_range(MaxLength + 1, 255)));
      return;
    end
    send_byte(len);
    acc = crc8_next(CrcInit, len);
    if (flaw == FlawCommand && max_cmd != 8'hFF) begin
      send_byte(8'($urandom_range(max_cmd + 1, 255)));
      return;
    end
    send_byte(cmd);
    acc  = crc8_next(acc, cmd);
    stop = (flaw == FlawCut) ? $urandom_range(0, n_data) : n_data;
    for (int i = 0; i < n_data; i++) begin
      if (i == stop) return;
      b = 8'($urandom_range(0, 255));
      send_byte(b);
      acc = crc8_next(acc, b);
    end
    if (flaw == FlawCut) return;
    send_byte((flaw == FlawCrcLo) ? acc ^ 8'($urandom_range(1, 255)) : acc);
    send_byte((flaw == FlawCrcHi) ? 8'($urandom_range(1, 255)) : CrcHiOk);
  endtask

  task automatic send_random_frame;
    int unsigned pick;
    int unsigned n_data;
    logic [7:0]  cmd;
    flaw_e       flaw;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 3))
      0:       cmd = fan_cmd;
      1:       cmd = leds_cmd;
      default: cmd = 8'($urandom_range(0, max_cmd));
    endcase
    if (cmd > max_cmd) cmd = 8'($urandom_range(0, max_cmd));
    n_data = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxDataBytes)
                                         : $urandom_range(0, 6);
    pick = $urandom_range(0, 99);
    if (pick < 70)      flaw = FlawNone;
    else if (pick < 76) flaw = FlawLength;
    else if (pick < 82) flaw = FlawCommand;
    else if (pick < 88) flaw = FlawCrcLo;
    else if (pick < 94) flaw = FlawCrcHi;
    else                flaw = FlawCut;
    send_frame(cmd, n_data, flaw);
  endtask

  task automatic pick_idling;
    tx_calm = ($urandom_range(0, 2) == 0);
    rx_calm = ($urandom_range(0, 2) == 0);
  endtask

  // reset values: fan, leds and empty-data frames, bad length and command
  task automatic test_frame_basics;
    send_frame(fan_cmd, 1, FlawNone);
    send_frame(leds_cmd, 4, FlawNone);
    send_frame(max_cmd, 0, FlawNone);
    send_frame(8'h00, 0, FlawLength);
    send_frame(8'h00, 0, FlawCommand);
  endtask

  // register extremes, fan and leds sharing a code, then the reset values
  task automatic test_config_sweep;
    logic [7:0] sets [5][4];
    sets = '{'{8'h00, 8'hFF, 8'h80, 8'h7F},
             '{8'hFF, 8'h00, 8'h00, 8'h00},
             '{8'h55, 8'd9,  8'd3,  8'd3},
             '{8'h00, 8'hFF, 8'hFF, 8'h00},
             '{8'hAA, 8'd6,  8'd4,  8'd5}};
    for (int s = 0; s < 5; s++) begin
      configure(sets[s][0], sets[s][1], sets[s][2], sets[s][3]);
      pick_idling();
      repeat (10) send_random_frame();
    end
  endtask

  // sink holds off while the source keeps offering back to back
  task automatic test_backpressure;
    drain();
    tx_calm  = 1'b1;
    rx_calm  = 1'b1;
    hold_req = 1'b1;
    repeat (5) send_random_frame();
    pick_idling();
  endtask

  task automatic test_random_traffic;
    int unsigned frames;
    logic [7:0]  mx;
    frames = 0;
    while (bytes_sent < ByteBudget) begin
      if (frames % 40 == 39) begin
        mx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(5, 20));
        configure(8'($urandom_range(0, 255)), mx, 8'($urandom_range(0, mx)),
                  8'($urandom_range(0, mx)));
      end
      if (frames % 10 == 0) pick_idling();
      send_random_frame();
      frames++;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    pick_idling();
    test_frame_basics();
    test_config_sweep();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
